/* rtl/core/cpp_pkg.sv */
// Shared constants, register codes and types for the camera projection block.
package cpp_pkg;

   // Default widths and fixed field layouts.
   localparam int CoordWidth      = 32;
   localparam int ScreenWidth     = 16;
   localparam int AxisField       = 16;
   localparam int AxisFrac        = 14;
   localparam int LensField       = 16;
   localparam int ResField        = 16;
   localparam int AxisWidth       = 48;
   localparam int LensWidth       = 48;
   localparam int ScreenSizeWidth = 32;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 48;
   localparam int QueueDepth      = 2;

   // Register reset values.
   localparam logic [AxisWidth-1:0]       RightAxisReset  = 48'd16384;
   localparam logic [AxisWidth-1:0]       UpAxisReset     = 48'd1073741824;
   localparam logic [AxisWidth-1:0]       ViewAxisReset   = 48'd70368744177664;
   localparam logic [LensWidth-1:0]       LensReset       = 48'd1099528470784;
   localparam logic [ScreenSizeWidth-1:0] ScreenSizeReset = 32'd0;

   // Register indexes on the configuration port.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_CENTER_Z      = 3'd2,
      CSR_RIGHT_AXIS    = 3'd3,
      CSR_UP_AXIS       = 3'd4,
      CSR_VIEW_AXIS     = 3'd5,
      CSR_LENS_GEOMETRY = 3'd6,
      CSR_SCREEN_SIZE   = 3'd7
   } csr_index_type;

   // Fill status of the queue between front and back.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

/* rtl/core/camera_perspective_projection.sv */
// Top level of the pinhole camera projection: registers, front, queue and back.
// Throughput: one request per clock; the back end's divider is fully pipelined per bit.
// The receiver cannot stall; busy only rises if the front-to-back queue were to fill.
// Reset is synchronous and active high: it empties the pipeline and queue and loads
// register defaults (center zero, identity axes, default lens, zero screen size).
module camera_perspective_projection #(
   parameter int COORD_WIDTH  = cpp_pkg::CoordWidth,
   parameter int SCREEN_WIDTH = cpp_pkg::ScreenWidth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  logic signed [COORD_WIDTH-1:0]         req_point_z,
   input  logic                                  req_is_direction,
   output logic                                  rsp_valid,
   output logic signed [COORD_WIDTH-1:0]         rsp_view_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_view_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_view_z,
   output logic signed [SCREEN_WIDTH-1:0]        rsp_screen_x,
   output logic signed [SCREEN_WIDTH-1:0]        rsp_screen_y,
   output logic                                  rsp_zero_depth,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cpp_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [cpp_pkg::CsrDataWidth-1:0]      csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = 3 * CW + 1;

   logic signed [CW-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [cpp_pkg::AxisWidth-1:0]       right_axis_ff, up_axis_ff, view_axis_ff;
   logic [cpp_pkg::LensWidth-1:0]       lens_ff;
   logic [cpp_pkg::ScreenSizeWidth-1:0] screen_size_ff;

   logic                      accept;
   logic                      fr_valid;
   logic signed [CW-1:0]      fr_view_x, fr_view_y, fr_view_z;
   logic                      fr_zero;
   logic [DW-1:0]             q_data;
   cpp_pkg::queue_status_type q_status;

   // Configuration writes are taken at any time.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         center_z_ff    <= '0;
         right_axis_ff  <= cpp_pkg::RightAxisReset;
         up_axis_ff     <= cpp_pkg::UpAxisReset;
         view_axis_ff   <= cpp_pkg::ViewAxisReset;
         lens_ff        <= cpp_pkg::LensReset;
         screen_size_ff <= cpp_pkg::ScreenSizeReset;
      end else if (csr_valid && csr_ready) begin
         unique case (cpp_pkg::csr_index_type'(csr_index))
            cpp_pkg::CSR_CENTER_X:      center_x_ff    <= $signed(csr_wdata[CW-1:0]);
            cpp_pkg::CSR_CENTER_Y:      center_y_ff    <= $signed(csr_wdata[CW-1:0]);
            cpp_pkg::CSR_CENTER_Z:      center_z_ff    <= $signed(csr_wdata[CW-1:0]);
            cpp_pkg::CSR_RIGHT_AXIS:    right_axis_ff  <= csr_wdata[cpp_pkg::AxisWidth-1:0];
            cpp_pkg::CSR_UP_AXIS:       up_axis_ff     <= csr_wdata[cpp_pkg::AxisWidth-1:0];
            cpp_pkg::CSR_VIEW_AXIS:     view_axis_ff   <= csr_wdata[cpp_pkg::AxisWidth-1:0];
            cpp_pkg::CSR_LENS_GEOMETRY: lens_ff        <= csr_wdata[cpp_pkg::LensWidth-1:0];
            cpp_pkg::CSR_SCREEN_SIZE:
               screen_size_ff <= csr_wdata[cpp_pkg::ScreenSizeWidth-1:0];
            default: ;
         endcase
      end
   end

   // A request enters whenever the queue has room.
   assign busy   = q_status.full;
   assign accept = start && !busy;

   cpp_front #(
      .CW (CW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .in_point_x      (req_point_x),
      .in_point_y      (req_point_y),
      .in_point_z      (req_point_z),
      .in_is_direction (req_is_direction),
      .center_x        (center_x_ff),
      .center_y        (center_y_ff),
      .center_z        (center_z_ff),
      .right_axis      (right_axis_ff),
      .up_axis         (up_axis_ff),
      .view_axis       (view_axis_ff),
      .out_valid       (fr_valid),
      .out_view_x      (fr_view_x),
      .out_view_y      (fr_view_y),
      .out_view_z      (fr_view_z),
      .out_zero_depth  (fr_zero)
   );

   cpp_queue #(
      .DW    (DW),
      .DEPTH (cpp_pkg::QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data ({fr_view_x, fr_view_y, fr_view_z, fr_zero}),
      .pop       (!q_status.empty),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // The back end never stalls, so the queue drains one entry per cycle.
   cpp_back #(
      .CW (CW),
      .SW (SCREEN_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (!q_status.empty),
      .in_view_x      ($signed(q_data[3*CW:2*CW+1])),
      .in_view_y      ($signed(q_data[2*CW:CW+1])),
      .in_view_z      ($signed(q_data[CW:1])),
      .in_zero_depth  (q_data[0]),
      .lens_geometry  (lens_ff),
      .screen_size    (screen_size_ff),
      .out_valid      (rsp_valid),
      .out_view_x     (rsp_view_x),
      .out_view_y     (rsp_view_y),
      .out_view_z     (rsp_view_z),
      .out_screen_x   (rsp_screen_x),
      .out_screen_y   (rsp_screen_y),
      .out_zero_depth (rsp_zero_depth)
   );

   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fr_valid |-> !q_status.full)
      else $error("front pushed into a full queue");

   // The depth flag follows the delivered depth.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero_depth == (rsp_view_z == '0)))
      else $error("zero depth flag disagrees with view depth");

   // Zero depth yields zero screen coordinates.
   a_zero_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_depth) |-> (rsp_screen_x == '0 && rsp_screen_y == '0))
      else $error("screen coordinates not cleared at zero depth");

endmodule

/* rtl/core/cpp_front.sv */
// Front end: takes requests, removes the camera center and forms view coordinates.
module cpp_front #(
   parameter int CW = cpp_pkg::CoordWidth
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [CW-1:0]                in_point_x,
   input  logic signed [CW-1:0]                in_point_y,
   input  logic signed [CW-1:0]                in_point_z,
   input  logic                                in_is_direction,
   input  logic signed [CW-1:0]                center_x,
   input  logic signed [CW-1:0]                center_y,
   input  logic signed [CW-1:0]                center_z,
   input  logic [cpp_pkg::AxisWidth-1:0]       right_axis,
   input  logic [cpp_pkg::AxisWidth-1:0]       up_axis,
   input  logic [cpp_pkg::AxisWidth-1:0]       view_axis,
   output logic                                out_valid,
   output logic signed [CW-1:0]                out_view_x,
   output logic signed [CW-1:0]                out_view_y,
   output logic signed [CW-1:0]                out_view_z,
   output logic                                out_zero_depth
);

   localparam int VW   = CW + 1;
   localparam int PW   = VW + cpp_pkg::AxisField;
   localparam int SUMW = PW + 2;
   localparam int QW   = SUMW - cpp_pkg::AxisFrac;
   localparam int Stages = 5;
   localparam logic [SUMW-1:0] RoundHalf = SUMW'(1) << (cpp_pkg::AxisFrac - 1);
   localparam logic [QW-1:0]   PosLimit  = (QW'(1) << (CW - 1)) - QW'(1);
   localparam logic [QW-1:0]   NegLimit  = QW'(1) << (CW - 1);

   logic               valid_ff [Stages];
   logic               valid_in [Stages];
   logic signed [VW-1:0] diff_ff  [3];
   logic signed [VW-1:0] diff_in  [3];
   logic signed [PW-1:0] prod_ff  [3][3];
   logic signed [PW-1:0] prod_in  [3][3];
   logic signed [SUMW-1:0] sum_ff [3];
   logic signed [SUMW-1:0] sum_in [3];
   logic [SUMW-1:0]      rnd_ff   [3];
   logic [SUMW-1:0]      rnd_in   [3];
   logic                 neg_ff   [3];
   logic                 neg_in   [3];
   logic signed [CW-1:0] view_ff  [3];
   logic signed [CW-1:0] view_in  [3];
   logic                 zero_ff;
   logic                 zero_in;
   logic signed [CW-1:0] point    [3];
   logic signed [CW-1:0] center   [3];
   logic [cpp_pkg::AxisWidth-1:0] axis [3];

   assign point[0]  = in_point_x;
   assign point[1]  = in_point_y;
   assign point[2]  = in_point_z;
   assign center[0] = center_x;
   assign center[1] = center_y;
   assign center[2] = center_z;
   assign axis[0]   = right_axis;
   assign axis[1]   = up_axis;
   assign axis[2]   = view_axis;

   // Valid bits march down the pipeline.
   always_comb begin
      valid_in[0] = in_valid;
      for (int s = 1; s < Stages; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   // Points are taken relative to the camera center; directions are not.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (in_is_direction) begin
            diff_in[k] = VW'(point[k]);
         end else begin
            diff_in[k] = VW'(point[k]) - VW'(center[k]);
         end
      end
   end

   // One product per axis and component.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[a][k] = PW'(diff_ff[k])
                          * PW'($signed(axis[a][cpp_pkg::AxisField*k +: cpp_pkg::AxisField]));
         end
      end
   end

   // Dot products, then magnitude plus half a unit for rounding away from zero.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = SUMW'(prod_ff[a][0]) + SUMW'(prod_ff[a][1]) + SUMW'(prod_ff[a][2]);
         neg_in[a] = sum_ff[a][SUMW-1];
         if (sum_ff[a][SUMW-1]) begin
            rnd_in[a] = ~sum_ff[a] + RoundHalf + SUMW'(1);
         end else begin
            rnd_in[a] = sum_ff[a] + RoundHalf;
         end
      end
   end

   // Drop the axis fraction, saturate and restore the sign.
   always_comb begin
      logic [QW-1:0] mag;
      logic [QW-1:0] lim;
      logic [CW-1:0] sat;
      for (int a = 0; a < 3; a++) begin
         mag = rnd_ff[a][SUMW-1:cpp_pkg::AxisFrac];
         lim = neg_ff[a] ? NegLimit : PosLimit;
         sat = (mag > lim) ? lim[CW-1:0] : mag[CW-1:0];
         view_in[a] = neg_ff[a] ? $signed(-sat) : $signed(sat);
      end
      zero_in = (view_in[2] == '0);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < Stages; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rnd_ff  <= rnd_in;
      neg_ff  <= neg_in;
      view_ff <= view_in;
      zero_ff <= zero_in;
   end

   assign out_valid      = valid_ff[Stages-1];
   assign out_view_x     = view_ff[0];
   assign out_view_y     = view_ff[1];
   assign out_view_z     = view_ff[2];
   assign out_zero_depth = zero_ff;

endmodule

/* rtl/core/cpp_queue.sv */
// Short queue of view coordinates between the front and the back.
module cpp_queue #(
   parameter int DW    = 97,
   parameter int DEPTH = cpp_pkg::QueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DW-1:0]             push_data,
   input  logic                      pop,
   output logic [DW-1:0]             pop_data,
   output cpp_pkg::queue_status_type status
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [DW-1:0]   entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign do_push = push && (count_ff != CNTW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNTW'(DEPTH));

endmodule

/* rtl/core/cpp_back.sv */
// Back end: projects view coordinates to screen pixels through pipelined dividers.
module cpp_back #(
   parameter int CW = cpp_pkg::CoordWidth,
   parameter int SW = cpp_pkg::ScreenWidth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [CW-1:0]                 in_view_x,
   input  logic signed [CW-1:0]                 in_view_y,
   input  logic signed [CW-1:0]                 in_view_z,
   input  logic                                 in_zero_depth,
   input  logic [cpp_pkg::LensWidth-1:0]        lens_geometry,
   input  logic [cpp_pkg::ScreenSizeWidth-1:0]  screen_size,
   output logic                                 out_valid,
   output logic signed [CW-1:0]                 out_view_x,
   output logic signed [CW-1:0]                 out_view_y,
   output logic signed [CW-1:0]                 out_view_z,
   output logic signed [SW-1:0]                 out_screen_x,
   output logic signed [SW-1:0]                 out_screen_y,
   output logic                                 out_zero_depth
);

   localparam int LF   = cpp_pkg::LensField;
   localparam int RF   = cpp_pkg::ResField;
   localparam int MW   = CW + LF;
   localparam int PSW  = MW + 2;
   localparam int PMW  = MW + 1;
   localparam int PRW  = PMW + RF;
   localparam int XW   = CW + SW + 34;
   localparam int QB   = SW + 1;
   localparam int Head = 6;
   localparam int Depth = Head + QB;
   localparam int SIDEW = 3 * CW + 1;
   localparam logic [SW-1:0] PosLimit = (SW'(1) << (SW - 1)) - SW'(1);
   localparam logic [SW-1:0] NegLimit = SW'(1) << (SW - 1);

   logic             valid_ff [Depth];
   logic [SIDEW-1:0] side_ff  [Depth];
   logic             out_valid_ff;
   logic [SIDEW-1:0] out_side_ff;
   logic [SW-1:0]    scr_ff [2];
   logic [SW-1:0]    scr_in [2];
   logic signed [CW-1:0] lane_view [2];

   assign lane_view[0] = in_view_x;
   assign lane_view[1] = in_view_y;

   // Valid line and the view values that ride along with each request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Depth; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < Depth; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= {in_view_x, in_view_y, in_view_z, in_zero_depth};
      for (int s = 1; s < Depth; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      out_side_ff <= side_ff[Depth-1];
      scr_ff      <= scr_in;
   end

   // One projection lane per screen axis; the vertical lane flips the sign.
   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      localparam logic Flip = (ln == 1);

      logic [LF-1:0] focal, half;
      logic [RF-1:0] res;
      logic [CW-1:0]  amag_ff, zmag_ff;
      logic           aneg_ff, zneg_ff;
      logic [MW-1:0]  t1_ff, t2_ff;
      logic           s1_ff, s2_ff;
      logic signed [PSW-1:0] p_ff, p_in;
      logic [MW-1:0]  dm3_ff, dm4_ff, dm5_ff;
      logic           zneg3_ff;
      logic [PMW-1:0] pmag_ff;
      logic           neg4_ff, neg5_ff, neg6_ff;
      logic [PRW-1:0] prod_ff;
      logic [XW-1:0]  x_ff, thr_ff, dm6_ff;
      logic [XW-1:0]  rem_ff [QB];
      logic [XW-1:0]  dmd_ff [QB];
      logic [QB-1:0]  q_ff   [QB];
      logic           negd_ff [QB];
      logic           ovf_ff  [QB];

      assign focal = lens_geometry[LF-1:0];
      assign half  = lens_geometry[LF*(ln+1) +: LF];
      assign res   = screen_size[RF*ln +: RF];

      // Magnitudes, products with focal distance and half extent.
      always_ff @(posedge clock) begin
         amag_ff <= lane_view[ln][CW-1] ? CW'(-lane_view[ln]) : CW'(lane_view[ln]);
         aneg_ff <= lane_view[ln][CW-1];
         zmag_ff <= in_view_z[CW-1] ? CW'(-in_view_z) : CW'(in_view_z);
         zneg_ff <= in_view_z[CW-1];
         t1_ff   <= MW'(amag_ff) * MW'(focal);
         t2_ff   <= MW'(zmag_ff) * MW'(half);
         s1_ff   <= aneg_ff ^ Flip;
         s2_ff   <= zneg_ff;
      end

      // Signed numerator a*d +/- z*h.
      always_comb begin
         logic signed [PSW-1:0] term1, term2;
         term1 = s1_ff ? -$signed(PSW'(t1_ff)) : $signed(PSW'(t1_ff));
         term2 = s2_ff ? -$signed(PSW'(t2_ff)) : $signed(PSW'(t2_ff));
         p_in  = term1 + term2;
      end

      // Scale by resolution and set up the division against z*h.
      always_ff @(posedge clock) begin
         p_ff     <= p_in;
         dm3_ff   <= t2_ff;
         zneg3_ff <= s2_ff;
         pmag_ff  <= p_ff[PSW-1] ? PMW'(-p_ff) : PMW'(p_ff);
         neg4_ff  <= p_ff[PSW-1] ^ zneg3_ff;
         dm4_ff   <= dm3_ff;
         prod_ff  <= PRW'(pmag_ff) * PRW'(res);
         neg5_ff  <= neg4_ff;
         dm5_ff   <= dm4_ff;
         x_ff     <= XW'(prod_ff) + XW'(dm5_ff);
         thr_ff   <= (XW'(dm5_ff) << SW) + (neg5_ff ? (XW'(dm5_ff) << 1) : '0);
         dm6_ff   <= XW'(dm5_ff);
         neg6_ff  <= neg5_ff;
      end

      // Restoring divider, one quotient bit per stage.
      for (genvar j = 0; j < QB; j++) begin : g_div
         logic [XW-1:0] rem_prev, dm_prev, shifted;
         logic [QB-1:0] q_prev;
         logic          neg_prev, ovf_prev, take;

         if (j == 0) begin : g_first
            assign rem_prev = x_ff;
            assign dm_prev  = dm6_ff;
            assign q_prev   = '0;
            assign neg_prev = neg6_ff;
            assign ovf_prev = (x_ff >= thr_ff);
         end else begin : g_next
            assign rem_prev = rem_ff[j-1];
            assign dm_prev  = dmd_ff[j-1];
            assign q_prev   = q_ff[j-1];
            assign neg_prev = negd_ff[j-1];
            assign ovf_prev = ovf_ff[j-1];
         end

         assign shifted = dm_prev << (QB - 1 - j);
         assign take    = (rem_prev >= shifted);

         always_ff @(posedge clock) begin
            rem_ff[j]  <= take ? rem_prev - shifted : rem_prev;
            q_ff[j]    <= q_prev | (take ? (QB'(1) << (QB - 1 - j)) : '0);
            dmd_ff[j]  <= dm_prev;
            negd_ff[j] <= neg_prev;
            ovf_ff[j]  <= ovf_prev;
         end
      end

      // Halve for round half up, saturate, apply sign, force zero on degenerate cases.
      always_comb begin
         logic [SW-1:0] r, lim, rs;
         logic          zd;
         r   = q_ff[QB-1][QB-1:1];
         lim = negd_ff[QB-1] ? NegLimit : PosLimit;
         rs  = (ovf_ff[QB-1] || (r > lim)) ? lim : r;
         zd  = side_ff[Depth-1][0];
         if (zd || (half == '0)) begin
            scr_in[ln] = '0;
         end else begin
            scr_in[ln] = negd_ff[QB-1] ? -rs : rs;
         end
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_view_x     = $signed(out_side_ff[3*CW:2*CW+1]);
   assign out_view_y     = $signed(out_side_ff[2*CW:CW+1]);
   assign out_view_z     = $signed(out_side_ff[CW:1]);
   assign out_zero_depth = out_side_ff[0];
   assign out_screen_x   = $signed(scr_ff[0]);
   assign out_screen_y   = $signed(scr_ff[1]);

endmodule
